/* rtl/core/sfm_pkg.sv */
package sfm_pkg;

  // Operand and result widths fixed by the field layout.
  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned RemW   = 63;
  // One restoring-remainder cell per dividend bit.
  localparam int unsigned NumCells = DataW;

  // Width select codes.
  localparam logic FuncW32 = 1'b0;
  localparam logic FuncW64 = 1'b1;

  // Per-beat payload handed from cell to cell.
  typedef struct packed {
    logic [RemW-1:0]  rem;     // partial remainder, below the modulus magnitude when that is nonzero
    logic [DataW-1:0] xbits;   // dividend magnitude bits not yet consumed, MSB first
    logic [DataW-1:0] mm;      // modulus magnitude
    logic             xneg;    // dividend sign
    logic             mneg;    // modulus sign
    logic             mzero;   // modulus in use is zero
  } cell_data_t;

endpackage

/* rtl/core/sfm_if.sv */
interface sfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [sfm_pkg::DataW-1:0] dividend;
  logic signed [sfm_pkg::DataW-1:0] modulus;

  modport source (output valid, output func, output dividend, output modulus, input ready);
  modport sink   (input valid, input func, input dividend, input modulus, output ready);
endinterface

interface sfm_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfm_pkg::RemW-1:0]   remainder;
  logic                       zero_divide;

  modport source (output valid, output remainder, output zero_divide, input ready);
  modport sink   (input valid, input remainder, input zero_divide, output ready);
endinterface

/* rtl/core/signed_fixed_modulo.sv */
// Pipeline: an accepted input beat passes 1 sign/magnitude stage, 64 remainder
//   cells and 1 correction stage before it leaves as its result beat.
// Throughput: one beat per cycle unless stalled, set by the one-bit-per-cell remainder chain.
// Each stage holds its beat under back-pressure; bubbles collapse, so input
//   is taken while any stage downstream is free.
// Reset: rst_ni (async, active low) clears all stage valid bits; data is not reset.
module signed_fixed_modulo (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfm_in_if.sink     in_i,
  sfm_out_if.source  out_o
);
  import sfm_pkg::*;

  // Handshake and payload between neighbors; index 0 is the prep output,
  // index NumCells is the last cell's output.
  logic       chain_valid [NumCells+1];
  logic       chain_ready [NumCells+1];
  cell_data_t chain_data  [NumCells+1];

  // Take magnitudes and signs, narrow mode sign-extends the low half.
  sfm_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .func_i     (in_i.func),
    .dividend_i (in_i.dividend),
    .modulus_i  (in_i.modulus),
    .valid_o    (chain_valid[0]),
    .ready_i    (chain_ready[0]),
    .data_o     (chain_data[0])
  );

  // One restoring step per cell, dividend MSB first. The remainder stays
  // below a nonzero modulus magnitude at every cell boundary.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    sfm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // Apply sign correction and the zero-modulus case; this is the output register.
  sfm_post u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (chain_valid[NumCells]),
    .ready_o       (chain_ready[NumCells]),
    .data_i        (chain_data[NumCells]),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .remainder_o   (out_o.remainder),
    .zero_divide_o (out_o.zero_divide)
  );

  // A zero modulus always yields a zero remainder.
  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divide |-> out_o.remainder == '0)
    else $error("zero_divide result carries a nonzero remainder");

  // Input stalls only when the whole chain is full and the output is held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready && chain_valid[NumCells])
    else $error("input stalled with room in the chain");

  // An accepted beat lands in the prep stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> chain_valid[0])
    else $error("accepted beat lost at prep stage");

  // A beat in the last cell moves on when the output stage is free.
  a_tail_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[NumCells] && !out_o.valid |=> out_o.valid)
    else $error("tail beat did not reach output register");

endmodule

/* rtl/core/sfm_prep.sv */
module sfm_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         func_i,
  input  logic [sfm_pkg::DataW-1:0]    dividend_i,
  input  logic [sfm_pkg::DataW-1:0]    modulus_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output sfm_pkg::cell_data_t          data_o
);
  import sfm_pkg::*;

  logic       valid_q;
  cell_data_t data_q, data_d;
  logic [DataW-1:0] x_ext, m_ext, x_mag, m_mag;

  // Sign-extend the low half in narrow mode.
  always_comb begin
    if (func_i == FuncW64) begin
      x_ext = dividend_i;
      m_ext = modulus_i;
    end else begin
      x_ext = {{(DataW-HalfW){dividend_i[HalfW-1]}}, dividend_i[HalfW-1:0]};
      m_ext = {{(DataW-HalfW){modulus_i[HalfW-1]}}, modulus_i[HalfW-1:0]};
    end
    x_mag = x_ext[DataW-1] ? (~x_ext + {{(DataW-1){1'b0}}, 1'b1}) : x_ext;
    m_mag = m_ext[DataW-1] ? (~m_ext + {{(DataW-1){1'b0}}, 1'b1}) : m_ext;
    data_d.rem   = '0;
    data_d.xbits = x_mag;
    data_d.mm    = m_mag;
    data_d.xneg  = x_ext[DataW-1];
    data_d.mneg  = m_ext[DataW-1];
    data_d.mzero = (m_ext == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/sfm_cell.sv */
module sfm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sfm_pkg::cell_data_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sfm_pkg::cell_data_t data_o
);
  import sfm_pkg::*;

  logic             valid_q;
  cell_data_t       data_q, data_d;
  logic [DataW-1:0] rem_sh;
  logic [DataW:0]   diff;

  // Shift in the next dividend bit, subtract the modulus if it fits.
  always_comb begin
    rem_sh = {data_i.rem, data_i.xbits[DataW-1]};
    diff   = {1'b0, rem_sh} - {1'b0, data_i.mm};
    data_d = data_i;
    data_d.xbits = {data_i.xbits[DataW-2:0], 1'b0};
    data_d.rem   = diff[DataW] ? rem_sh[RemW-1:0] : diff[RemW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/sfm_post.sv */
module sfm_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  sfm_pkg::cell_data_t       data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [sfm_pkg::RemW-1:0]  remainder_o,
  output logic                      zero_divide_o
);
  import sfm_pkg::*;

  logic             valid_q;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             zdiv_q;
  logic [DataW-1:0] wrapped;

  // Fold the magnitude remainder into [0, |modulus|) when the signs differ; a zero modulus gives zero.
  always_comb begin
    wrapped = data_i.mm - {1'b0, data_i.rem};
    if (data_i.mzero) begin
      rem_d = '0;
    end else if ((data_i.xneg != data_i.mneg) && (data_i.rem != '0)) begin
      rem_d = wrapped[RemW-1:0];
    end else begin
      rem_d = data_i.rem;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      zdiv_q <= data_i.mzero;
    end
  end

  assign valid_o       = valid_q;
  assign remainder_o   = rem_q;
  assign zero_divide_o = zdiv_q;

endmodule

/* bench/signed_fixed_modulo_tb.sv */
`timescale 1ns / 100ps

module signed_fixed_modulo_tb;
  import sfm_pkg::*;

  // Run shape
  localparam int unsigned RandomItems   = 1826;
  localparam int unsigned PipeLatency   = 66;
  localparam int unsigned TailCycles    = PipeLatency + 20;
  localparam int unsigned RxHoldCycles  = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxReported   = 10;

  // Handy operand corners
  localparam logic [DataW-1:0] Min64 = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] Min32 = 64'h0000_0000_8000_0000;
  localparam logic [DataW-1:0] Max32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [DataW-1:0] AllOnes = '1;

  // One predicted result beat, with the operands kept for the mismatch report.
  typedef struct {
    logic             func;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] modulus;
    logic [RemW-1:0]  remainder;
    logic             zero_divide;
  } mod_result_t;

  // Predicts each result from the operands seen at the input and checks the
  // output beats against them in order.
  class modulo_scoreboard;
    mod_result_t expected_q[$];
    int unsigned n_fail;

    function new();
      n_fail = 0;
    endfunction

    // Magnitude of a 32- or 64-bit two's-complement operand. The most negative
    // value maps to 2^(W-1), which still fits the 64-bit unsigned result.
    function logic [DataW-1:0] abs_operand(input logic [DataW-1:0] v, input logic wide,
                                           output logic neg);
      logic [DataW-1:0] ext;
      ext = wide ? v : {{HalfW{v[HalfW-1]}}, v[HalfW-1:0]};
      neg = ext[DataW-1];
      return neg ? (~ext + 1'b1) : ext;
    endfunction

    function mod_result_t expected_modulo(input logic f, input logic [DataW-1:0] x,
                                          input logic [DataW-1:0] m);
      mod_result_t res;
      logic [DataW-1:0] x_mag, m_mag, rem;
      logic x_neg, m_neg;
      res.func = f;
      res.dividend = x;
      res.modulus = m;
      x_mag = abs_operand(x, f == FuncW64, x_neg);
      m_mag = abs_operand(m, f == FuncW64, m_neg);
      if (m_mag == '0) begin
        res.remainder = '0;
        res.zero_divide = 1'b1;
      end else begin
        rem = x_mag % m_mag;
        // fold into [0, |m|) when the signs differ
        if (x_neg != m_neg && rem != '0) rem = m_mag - rem;
        res.remainder = rem[RemW-1:0];
        res.zero_divide = 1'b0;
      end
      return res;
    endfunction

    function void note_operands(input logic f, input logic [DataW-1:0] x,
                                input logic [DataW-1:0] m);
      expected_q.push_back(expected_modulo(f, x, m));
    endfunction

    function void check_result(input logic [RemW-1:0] rem, input logic zd);
      mod_result_t exp_res;
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MaxReported)
          $display("[%0t] unexpected result beat: remainder=%h zero_divide=%b", $time, rem, zd);
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.remainder !== rem || exp_res.zero_divide !== zd) begin
        n_fail++;
        if (n_fail <= MaxReported)
          $display("[%0t] mismatch func=%b x=%h m=%h: exp rem=%h zd=%b, got rem=%h zd=%b",
                   $time, exp_res.func, exp_res.dividend, exp_res.modulus,
                   exp_res.remainder, exp_res.zero_divide, rem, zd);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sfm_in_if  in_if ();
  sfm_out_if out_if ();

  signed_fixed_modulo dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  modulo_scoreboard sb;

  // Idle control shared by the two drivers. no_idle gives a stretch with
  // valid and ready held high; rx_hold_req asks the receiver for one long
  // hold-off so the pipeline fills and back-pressures the input.
  logic no_idle;
  logic rx_hold_req;
  int unsigned stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  // Operand with W-bit structure: full random, random bit length, corners,
  // small values and powers of two. In 32-bit mode the upper half is junk.
  function automatic logic [DataW-1:0] rand_operand(input logic wide);
    logic [DataW-1:0] v;
    int unsigned w;
    int unsigned sel;
    w = wide ? DataW : HalfW;
    v = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    case (sel)
      3, 4, 5: begin
        v = v >> (DataW - $urandom_range(1, w));
        if ($urandom_range(0, 1)) v = -v;
      end
      6: begin
        case ($urandom_range(0, 3))
          0: v = 64'd1 << (w - 1);
          1: v = (64'd1 << (w - 1)) - 1;
          2: v = (64'd1 << (w - 1)) + 1;
          default: v = AllOnes;
        endcase
      end
      7: begin
        v = $urandom_range(0, 16);
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        v = 64'd1 << $urandom_range(0, w - 1);
        if ($urandom_range(0, 1)) v = v - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: ;
    endcase
    if (!wide) v[DataW-1:HalfW] = $urandom;
    return v;
  endfunction

  // Offer one beat and hold it until the block takes it. valid stays high on
  // return so back-to-back beats need no extra assignment.
  task automatic send_beat(input logic f, input logic [DataW-1:0] x,
                           input logic [DataW-1:0] m);
    in_if.valid    <= 1'b1;
    in_if.func     <= f;
    in_if.dividend <= x;
    in_if.modulus  <= m;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid for the requested gap n; a zero gap leaves valid untouched.
  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic do_item(input logic f, input logic [DataW-1:0] x, input logic [DataW-1:0] m);
    idle_gap((no_idle || rx_hold_req) ? 0 : rand_gap());
    send_beat(f, x, m);
  endtask

  // Stop offering and wait until every result in flight has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Receiver: alternating ready and stall bursts, one long hold-off on request.
  initial begin : rx_drive
    int unsigned left;
    logic phase;
    left = 0;
    phase = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
        phase = 1'b1;
        left = $urandom_range(1, 24);
        out_if.ready <= 1'b1;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        if (left == 0) begin
          phase = !phase;
          left = phase ? $urandom_range(1, 24) : rand_gap();
          if (left == 0) begin
            phase = 1'b1;
            left = $urandom_range(1, 24);
          end
        end
        out_if.ready <= phase;
        left--;
      end
    end
  end

  // Monitor both channels at the clock edge; all inputs change by nonblocking
  // assignment, so what is read here is the value the block saw at this edge.
  // The watchdog restarts on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_operands(in_if.func, in_if.dividend, in_if.modulus);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.remainder, out_if.zero_divide);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 stall_cycles, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic f;
    logic [DataW-1:0] x, m;
    int unsigned r;
    int k;
    sb = new();
    stall_cycles = 0;
    no_idle = 1'b0;
    rx_hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FuncW32;
    in_if.dividend = '0;
    in_if.modulus = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 64-bit: every sign combination, zero remainder with mixed signs,
    // zero modulus, most negative operands, full-width results.
    do_item(FuncW64, 64'd7, 64'd3);
    do_item(FuncW64, -64'sd7, 64'd3);
    do_item(FuncW64, 64'd7, -64'sd3);
    do_item(FuncW64, -64'sd7, -64'sd3);
    do_item(FuncW64, -64'sd9, 64'd3);
    do_item(FuncW64, 64'd5, 64'd0);
    do_item(FuncW64, Min64, 64'd0);
    do_item(FuncW64, Min64, 64'd7);
    do_item(FuncW64, Min64, Min64);
    do_item(FuncW64, 64'd1, Min64);
    do_item(FuncW64, Max64, Min64);
    do_item(FuncW64, Min64, AllOnes);
    do_item(FuncW64, Max64, Max64);
    do_item(FuncW64, 64'd0, -64'sd5);
    do_item(FuncW64, AllOnes, Max64);
    // 32-bit: upper halves are junk and must be ignored, including a modulus
    // that is zero only in its low half.
    do_item(FuncW32, {32'hFFFF_FFFF, 32'd7}, {32'h1234_5678, 32'd3});
    do_item(FuncW32, {32'h0000_0000, 32'hFFFF_FFF9}, 64'd3);
    do_item(FuncW32, 64'd5, {32'hDEAD_BEEF, 32'h0});
    do_item(FuncW32, {32'hA5A5_A5A5, Min32[31:0]}, 64'd7);
    do_item(FuncW32, Min32, {32'h5A5A_5A5A, Min32[31:0]});
    do_item(FuncW32, 64'd1, Min32);
    do_item(FuncW32, Max32, {32'h0, 32'hFFFF_FFFF});
    do_item(FuncW32, {32'hFFFF_FFFF, 32'h0}, 64'd5);
    do_item(FuncW32, AllOnes, Max32);

    // Random phase with the pressure points placed along the way.
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == 500) rx_hold_req = 1'b1;
      if (i == 900) no_idle = 1'b1;
      if (i == 1100) no_idle = 1'b0;
      if (i == 1400) drain_results();

      f = $urandom_range(0, 1);
      m = rand_operand(f);
      x = rand_operand(f);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // zero modulus, junk above in 32-bit mode
        m = (f == FuncW64) ? 64'd0 : {$urandom, 32'd0};
      end else if (r < 14) begin
        // exact multiple unless the product wraps: remainder is then zero whatever the signs
        k = $urandom_range(0, 9);
        if ($urandom_range(0, 1)) k = -k;
        x = m * DataW'(k);
        if (f == FuncW32) x[DataW-1:HalfW] = $urandom;
      end
      do_item(f, x, m);
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.n_fail, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* signed_fixed_modulo.f */
rtl/core/sfm_pkg.sv
rtl/core/sfm_if.sv
rtl/core/sfm_prep.sv
rtl/core/sfm_cell.sv
rtl/core/sfm_post.sv
rtl/core/signed_fixed_modulo.sv
bench/signed_fixed_modulo_tb.sv
